// ===== rtl/nsqrt_pkg.sv =====
// Shared constant for the fixed-point square root block.
`default_nettype none

package nsqrt_pkg;

   // Width of the root field on the result channel
   localparam int ROOT_WIDTH = 24;

endpackage

`default_nettype wire

// ===== rtl/newton_square_root.sv =====
// Top level: sequencer around the digit step unit for the fixed-point floor square root.
// A run is PAIRS = (RADICAND_WIDTH + FRAC_BITS + 1) / 2 digit steps, 24 at the Q16.16
// default format, and the rsp_valid strobe is registered after the last step.
// Throughput: the single compare-and-subtract unit settles one root bit per cycle; a new
// start is not taken during a run, but is taken in the cycle the result is strobed.
// Reset (synchronous, active high) returns the sequencer to idle and drops the strobe.
// The result is strobed for one cycle and the receiver cannot stall it.
`default_nettype none

module newton_square_root import nsqrt_pkg::*; #(
   parameter int RADICAND_WIDTH = 32,
   parameter int FRAC_BITS      = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [RADICAND_WIDTH-1:0] req_radicand,
   output logic                           rsp_valid,
   output logic [ROOT_WIDTH-1:0]          rsp_root
);

   localparam int TOTAL = RADICAND_WIDTH + FRAC_BITS;
   localparam int PAIRS = (TOTAL + 1) / 2;
   localparam int SW    = 2 * PAIRS;
   localparam int CW    = $clog2(PAIRS + 1);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type                 state_ff, state_in;
   logic [SW-1:0]             shift_ff, shift_in;
   logic [PAIRS+1:0]          rem_ff, rem_in;
   logic [PAIRS-1:0]          root_ff, root_in;
   logic [CW-1:0]             count_ff, count_in;
   logic                      valid_ff, valid_in;
   logic [ROOT_WIDTH-1:0]     out_root_ff, out_root_in;

   logic [PAIRS+1:0]          step_rem;
   logic [PAIRS-1:0]          step_root;
   logic [ROOT_WIDTH+PAIRS-1:0] root_wide;
   logic                      take;

   // Shared digit step unit
   nsqrt_step #(
      .PAIRS(PAIRS)
   ) u_step (
      .rem_cur  (rem_ff),
      .root_cur (root_ff),
      .pair     (shift_ff[SW-1:SW-2]),
      .rem_next (step_rem),
      .root_next(step_root)
   );

   assign take      = start && (state_ff == ST_IDLE);
   assign root_wide = {{ROOT_WIDTH{1'b0}}, step_root};

   // Sequence the digit steps, one root bit per cycle
   always_comb begin
      state_in    = state_ff;
      shift_in    = shift_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      count_in    = count_ff;
      valid_in    = 1'b0;
      out_root_in = out_root_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               shift_in = SW'(req_radicand) << FRAC_BITS;
               rem_in   = '0;
               root_in  = '0;
               count_in = CW'(PAIRS);
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            shift_in = {shift_ff[SW-3:0], 2'b00};
            rem_in   = step_rem;
            root_in  = step_root;
            count_in = count_ff - CW'(1);
            if (count_ff == CW'(1)) begin
               valid_in    = 1'b1;
               out_root_in = root_wide[ROOT_WIDTH-1:0];
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
      shift_ff    <= shift_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      out_root_ff <= out_root_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_root  = out_root_ff;

   // A start transfer always launches a run
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("start transfer did not launch a run");

   // The last digit step strobes a result
   a_last_step_strobes: assert property (@(posedge clock) disable iff (reset)
      (busy && (count_ff == CW'(1))) |=> rsp_valid)
      else $error("final step produced no result");

   // A result strobe lasts exactly one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held more than one cycle");

   // A result is only strobed once the run has ended
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while still running");

   // The step counter never runs out while busy
   a_count_live: assert property (@(posedge clock) disable iff (reset)
      busy |-> (count_ff != '0))
      else $error("step counter empty during a run");

endmodule

`default_nettype wire

// ===== rtl/nsqrt_step.sv =====
// One restoring square-root digit step: shift in a bit pair, trial subtract, form one root bit.
`default_nettype none

module nsqrt_step #(
   parameter int PAIRS = 24
) (
   input  wire logic [PAIRS+1:0] rem_cur,
   input  wire logic [PAIRS-1:0] root_cur,
   input  wire logic [1:0]       pair,
   output logic      [PAIRS+1:0] rem_next,
   output logic      [PAIRS-1:0] root_next
);

   logic [PAIRS+1:0] rem_shift;
   logic [PAIRS+1:0] trial;
   logic [PAIRS+1:0] diff;
   logic             fits;

   // Bring down the next pair and build the trial 4*root + 1
   assign rem_shift = {rem_cur[PAIRS-1:0], pair};
   assign trial     = {root_cur, 2'b01};

   // Shared compare and subtract
   assign fits = (rem_shift >= trial);
   assign diff = rem_shift - trial;

   // Keep the difference when the trial fits and append the root bit
   assign rem_next  = fits ? diff : rem_shift;
   assign root_next = {root_cur[PAIRS-2:0], fits};

endmodule

`default_nettype wire
